// ===== rtl/tat_pkg.sv =====
// Shared constants and the arctangent table of the tilt angle tracker.
// No dependencies; every other file of the block refers to it by scoped names.
package tat_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TILT_BITS_DEF   = 16;

  localparam int CORDIC_STEPS = 16;

  // Reference reset values, signed with LSB 2^-24 (5.608387 and 8.043009).
  localparam longint REF_RESET_Y = 64'sd94093120;
  localparam longint REF_RESET_Z = 64'sd134939299;

  localparam logic [4:0] SHIFT_RESET = 5'd10;
  localparam logic [4:0] SHIFT_MIN   = 5'd1;
  localparam logic [4:0] SHIFT_MAX   = 5'd16;

  // Width of the rotation datapath; pi/4 equals 2^29 angle units.
  localparam int XW = 64;
  localparam int ZW = 32;

  // atan(2^-i) in units where pi/4 is 2^29.
  function automatic logic [ZW-1:0] atan_unit(input logic [3:0] i);
    logic [ZW-1:0] v;
    case (i)
      4'd0:    v = 32'h2000_0000;
      4'd1:    v = 32'h12E4_051E;
      4'd2:    v = 32'h09FB_385B;
      4'd3:    v = 32'h0511_11D4;
      4'd4:    v = 32'h028B_0D43;
      4'd5:    v = 32'h0145_D7E1;
      4'd6:    v = 32'h00A2_F61E;
      4'd7:    v = 32'h0051_7C55;
      4'd8:    v = 32'h0028_BE53;
      4'd9:    v = 32'h0014_5F2F;
      4'd10:   v = 32'h000A_2F98;
      4'd11:   v = 32'h0005_17CC;
      4'd12:   v = 32'h0002_8BE6;
      4'd13:   v = 32'h0001_45F3;
      4'd14:   v = 32'h0000_A2FA;
      4'd15:   v = 32'h0000_517D;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/tat_sample_if.sv =====
// Valid/ready channel that carries one Y/Z accelerometer word.
// Depends on tat_pkg for the default sample width.
interface tat_sample_if #(
  parameter int SAMPLE_BITS = tat_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] accel_y;
  logic signed [SAMPLE_BITS-1:0] accel_z;

  modport source (output valid, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_y, input accel_z, output ready);
endinterface

// ===== rtl/tat_result_if.sv =====
// Valid/ready channel that carries one tilt level word and its clamp flag.
// Depends on tat_pkg for the default level width.
interface tat_result_if #(
  parameter int TILT_BITS = tat_pkg::TILT_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic [TILT_BITS-1:0] tilt_level;
  logic                 angle_clamped;

  modport source (output valid, output tilt_level, output angle_clamped, input ready);
  modport sink   (input valid, input tilt_level, input angle_clamped, output ready);
endinterface

// ===== rtl/tilt_angle_tracker.sv =====
// Tilt angle tracker top level: sequencer, shared multiplier, CORDIC, reference update.
// Depends on tat_pkg, tat_sample_if and tat_result_if.

// Each accepted sample word (accel_y, accel_z) is compared with a slowly
// adapting reference vector: the block forms dot = rz*z + ry*y and
// cross = rz*y - ry*z with one shared multiplier (one product a cycle),
// decides the clamp case exactly on those integers, and otherwise
// finds atan2(cross, dot) with a 16-step CORDIC in vectoring mode after a
// normalization pass that shifts by 8 or by 1 bit a cycle. The angle, limited
// to +-pi/4, leaves as an unsigned tilt_level where -pi/4 is 0 and +pi/4 is
// full scale; angle_clamped flags a sample outside that range. After the angle
// is found, each reference component moves toward the sample by
// floor((sample*2^16 - ref) / 2^shift), the shift coming from cfg_wdata
// (values 0 and 17..31 act as 1 and 16). From one accepted sample to the
// earliest acceptance of the next, a clamped or zero sample passes through
// acceptance, the multiplier phase, the decision and the delivery. Any
// other sample also passes through the normalization, one step per shift
// and one exit check, and the sixteen CORDIC iterations of the one shared
// rotation unit, between the decision and the delivery. The block takes one
// sample at a time; a finished result waits in an output register, and the
// next sample is taken while it waits. A result that finds the output
// register still occupied waits in the delivery state until the register
// is free, and the input is not ready meanwhile.
module tilt_angle_tracker #(
  parameter int SAMPLE_BITS = tat_pkg::SAMPLE_BITS_DEF,
  parameter int TILT_BITS   = tat_pkg::TILT_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [4:0]           cfg_wdata,
  tat_sample_if.sink           sample,
  tat_result_if.source         result
);

  // Reference width (LSB 2^-24 at the default width) and the pre-shift that
  // keeps the products inside 64 bits for wide samples.
  localparam int RW = SAMPLE_BITS + 16;
  localparam int PS = (SAMPLE_BITS > 23) ? 2 * SAMPLE_BITS - 47 : 0;
  localparam int AW = RW - PS;
  localparam int PW = AW + SAMPLE_BITS;
  localparam int DW = PW + 1;
  localparam int XW = tat_pkg::XW;
  localparam int ZW = tat_pkg::ZW;

  // Reset values saturated to the range of the reference.
  localparam longint RefLim  = longint'(1) <<< (SAMPLE_BITS + 15);
  localparam longint RefYSat = (tat_pkg::REF_RESET_Y > RefLim - 1) ? RefLim - 1 :
                               tat_pkg::REF_RESET_Y;
  localparam longint RefZSat = (tat_pkg::REF_RESET_Z > RefLim - 1) ? RefLim - 1 :
                               tat_pkg::REF_RESET_Z;
  localparam logic signed [RW-1:0] REF_Y_RST = RW'(RefYSat);
  localparam logic signed [RW-1:0] REF_Z_RST = RW'(RefZSat);

  // Level rounding: the angle unit pi/4 = 2^29 maps to half of full scale.
  localparam int RND = 29 - TILT_BITS;
  localparam int LSH = 30 - TILT_BITS;

  localparam logic [2:0] MUL_LAST = 3'd4;
  localparam logic [3:0] ROT_LAST = 4'(tat_pkg::CORDIC_STEPS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DECIDE,
    S_NORM,
    S_ROT,
    S_FIN
  } state_t;

  state_t state;

  // Sample and reference registers.
  logic signed [SAMPLE_BITS-1:0] sy;
  logic signed [SAMPLE_BITS-1:0] sz;
  logic signed [RW-1:0]          ref_y;
  logic signed [RW-1:0]          ref_z;
  logic [4:0]                    shift_cfg;

  // Product phase.
  logic [2:0]           mul_k;
  logic signed [AW-1:0] ry_s;
  logic signed [AW-1:0] rz_s;
  logic signed [AW-1:0] mul_a;
  logic signed [SAMPLE_BITS-1:0] mul_b;
  logic signed [PW-1:0] prod_comb;
  logic signed [PW-1:0] prod;
  logic signed [DW-1:0] dot;
  logic signed [DW-1:0] crs;

  // Decision.
  logic signed [DW:0] dot_e;
  logic signed [DW:0] cross_e;
  logic signed [DW:0] ncross_e;
  logic               is_zero;
  logic               is_inside;

  // CORDIC.
  logic signed [XW-1:0] x;
  logic signed [XW-1:0] y;
  logic signed [ZW-1:0] zacc;
  logic [3:0]           step;
  logic signed [XW-1:0] dx;
  logic signed [XW-1:0] dy;
  logic signed [ZW-1:0] atan_s;

  // Result held until the angle is final.
  logic                 use_cordic;
  logic [TILT_BITS-1:0] res_level;
  logic                 res_clamped;

  // Level from the CORDIC angle.
  logic signed [32:0]   z_rnd;
  logic signed [32:0]   z_sh;
  logic signed [32:0]   lvl_s;
  logic [TILT_BITS-1:0] cordic_level;

  // Reference update.
  logic [4:0]         shift_eff;
  logic signed [RW:0] diff_y;
  logic signed [RW:0] diff_z;
  logic signed [RW:0] sum_y;
  logic signed [RW:0] sum_z;
  logic signed [RW-1:0] ref_y_next;
  logic signed [RW-1:0] ref_z_next;

  // Output register.
  logic                 out_valid;
  logic [TILT_BITS-1:0] out_level;
  logic                 out_clamped;
  logic                 out_free;

  assign sample.ready         = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.tilt_level    = out_level;
  assign result.angle_clamped = out_clamped;
  assign out_free             = !out_valid || result.ready;

  // Shared multiplier: k=0 rz*sz, k=1 ry*sy, k=2 rz*sy, k=3 ry*sz.
  assign ry_s      = AW'(ref_y >>> PS);
  assign rz_s      = AW'(ref_z >>> PS);
  assign mul_a     = (mul_k == 3'd0 || mul_k == 3'd2) ? rz_s : ry_s;
  assign mul_b     = (mul_k == 3'd0 || mul_k == 3'd3) ? sz : sy;
  assign prod_comb = mul_a * mul_b;

  // Exact clamp decision: inside when dot > 0 and |cross| <= dot.
  assign dot_e     = (DW+1)'(dot);
  assign cross_e   = (DW+1)'(crs);
  assign ncross_e  = -cross_e;
  assign is_zero   = (dot == '0) && (crs == '0);
  assign is_inside = (dot_e > 0) && (cross_e <= dot_e) && (ncross_e <= dot_e);

  // One rotation step; arithmetic shifts round toward minus infinity.
  assign dx     = y >>> step;
  assign dy     = x >>> step;
  assign atan_s = signed'(tat_pkg::atan_unit(step));

  assign z_rnd = 33'(zacc) + (33'sd1 <<< RND);
  assign z_sh  = z_rnd >>> LSH;
  assign lvl_s = (33'sd1 <<< (TILT_BITS - 1)) + z_sh;

  always_comb begin
    if (lvl_s < 0) begin
      cordic_level = '0;
    end else if (lvl_s > (33'sd1 <<< TILT_BITS) - 33'sd1) begin
      cordic_level = '1;
    end else begin
      cordic_level = TILT_BITS'(lvl_s);
    end
  end

  // Averaging shift limited to its working range.
  always_comb begin
    if (shift_cfg < tat_pkg::SHIFT_MIN) begin
      shift_eff = tat_pkg::SHIFT_MIN;
    end else if (shift_cfg > tat_pkg::SHIFT_MAX) begin
      shift_eff = tat_pkg::SHIFT_MAX;
    end else begin
      shift_eff = shift_cfg;
    end
  end

  // The sum always lies between the old reference and the sample, but it is
  // saturated to the reference range all the same.
  assign diff_y = ((RW+1)'(sy) <<< 16) - (RW+1)'(ref_y);
  assign diff_z = ((RW+1)'(sz) <<< 16) - (RW+1)'(ref_z);
  assign sum_y  = (RW+1)'(ref_y) + (diff_y >>> shift_eff);
  assign sum_z  = (RW+1)'(ref_z) + (diff_z >>> shift_eff);

  always_comb begin
    if (sum_y[RW] != sum_y[RW-1]) begin
      ref_y_next = sum_y[RW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
    end else begin
      ref_y_next = RW'(sum_y);
    end
    if (sum_z[RW] != sum_z[RW-1]) begin
      ref_z_next = sum_z[RW] ? {1'b1, {(RW-1){1'b0}}} : {1'b0, {(RW-1){1'b1}}};
    end else begin
      ref_z_next = RW'(sum_z);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ref_y     <= REF_Y_RST;
      ref_z     <= REF_Z_RST;
      shift_cfg <= tat_pkg::SHIFT_RESET;
      out_valid <= 1'b0;
      mul_k     <= '0;
      step      <= '0;
    end else begin
      if (cfg_we) begin
        shift_cfg <= cfg_wdata;
      end
      // In the delivery state the register is refilled instead of cleared.
      if (out_valid && result.ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            sy    <= sample.accel_y;
            sz    <= sample.accel_z;
            mul_k <= '0;
            state <= S_MUL;
          end
        end

        // The product of one cycle is accumulated in the next.
        S_MUL: begin
          prod <= prod_comb;
          case (mul_k)
            3'd1:    dot <= DW'(prod);
            3'd2:    dot <= dot + DW'(prod);
            3'd3:    crs <= DW'(prod);
            3'd4:    crs <= crs - DW'(prod);
            default: ;
          endcase
          if (mul_k == MUL_LAST) begin
            state <= S_DECIDE;
          end
          mul_k <= mul_k + 3'd1;
        end

        S_DECIDE: begin
          x    <= XW'(dot);
          y    <= XW'(crs);
          zacc <= '0;
          step <= '0;
          if (is_zero) begin
            use_cordic  <= 1'b0;
            res_level   <= {1'b1, {(TILT_BITS-1){1'b0}}};
            res_clamped <= 1'b0;
            state       <= S_FIN;
          end else if (is_inside) begin
            use_cordic  <= 1'b1;
            res_clamped <= 1'b0;
            state       <= S_NORM;
          end else begin
            use_cordic  <= 1'b0;
            res_level   <= (crs >= 0) ? '1 : '0;
            res_clamped <= 1'b1;
            state       <= S_FIN;
          end
        end

        // Bring x into [2^59, 2^60); y follows with the same shift.
        S_NORM: begin
          if (x[XW-1:60] != '0) begin
            x <= x >>> 1;
            y <= y >>> 1;
          end else if (x[XW-1:51] == '0) begin
            x <= x <<< 8;
            y <= y <<< 8;
          end else if (x[XW-1:59] == '0) begin
            x <= x <<< 1;
            y <= y <<< 1;
          end else begin
            state <= S_ROT;
          end
        end

        S_ROT: begin
          if (!y[XW-1]) begin
            x    <= x + dx;
            y    <= y - dy;
            zacc <= zacc + atan_s;
          end else begin
            x    <= x - dx;
            y    <= y + dy;
            zacc <= zacc - atan_s;
          end
          if (step == ROT_LAST) begin
            state <= S_FIN;
          end
          step <= step + 4'd1;
        end

        // Deliver the word once the output register is free, then adapt.
        S_FIN: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            out_level   <= use_cordic ? cordic_level : res_level;
            out_clamped <= res_clamped;
            ref_y       <= ref_y_next;
            ref_z       <= ref_z_next;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the tilt angle tracker: clocked driver and monitor
// around a built-in tilt predictor. Depends on tat_pkg, tat_sample_if, tat_result_if and tilt_angle_tracker.
module testbench;

  localparam int SB = tat_pkg::SAMPLE_BITS_DEF;
  localparam int TB = tat_pkg::TILT_BITS_DEF;

  // Angle units: pi/4 is 2^29. Normalization window of the rotation input.
  localparam longint NORM_LO   = 64'sd1 <<< 59;
  localparam longint NORM_HI   = 64'sd1 <<< 60;
  localparam longint LEVEL_MID = 64'sd1 <<< (TB - 1);
  localparam longint LEVEL_TOP = (64'sd1 <<< TB) - 1;
  localparam longint LEVEL_RND = 64'sd1 <<< (29 - TB);
  localparam longint REF_LIM   = 64'sd1 <<< (SB + 15);

  // Settle time covers the longest path of a sample through the block.
  localparam int SETTLE_CYCLES = 48;
  localparam int RUN_LIMIT     = 300000;
  localparam int LONG_HOLD     = 500;
  localparam int HOLD_AFTER    = 150;

  typedef struct packed {
    logic signed [SB-1:0] y;
    logic signed [SB-1:0] z;
  } accel_word_t;

  typedef struct packed {
    logic [TB-1:0] level;
    logic          clamp;
  } tilt_word_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  tat_sample_if s_if ();
  tat_result_if r_if ();

  tilt_angle_tracker u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (s_if),
    .result    (r_if)
  );

  // arctan(2^-k) in angle units, one entry per rotation step.
  longint atan_tab [16] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
    64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
    64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
    64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D
  };

  // Shadow of the block's state: the gravity reference (LSB 2^-24) and the
  // smoothing shift as last written.
  longint     gravity_ref_y;
  longint     gravity_ref_z;
  logic [4:0] shift_shadow;

  accel_word_t accel_pending_q[$];
  tilt_word_t  tilt_expect_q[$];

  int  mismatches;
  int  levels_seen;
  int  hold_left;
  bit  hold_done;
  bit  calm;
  int  send_gap;
  int  take_gap;
  int  cycle_count;

  accel_word_t next_word;
  tilt_word_t  want_word;
  tilt_word_t  got_word;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Works out the tilt word for one accepted sample, then moves the reference
  // toward the sample the same way the block does.
  task automatic track_tilt(input logic signed [SB-1:0] ay, input logic signed [SB-1:0] az,
                            output tilt_word_t res);
    longint sy, sz, dot, crs, xr, yr, ang, lvl, dx, dy;
    int     k;
    int     sh;
    sy  = longint'(ay);
    sz  = longint'(az);
    dot = gravity_ref_z * sz + gravity_ref_y * sy;
    crs = gravity_ref_z * sy - gravity_ref_y * sz;
    res.clamp = 1'b0;
    if (dot == 0 && crs == 0) begin
      // A zero vector has no direction; it reads as level ground.
      lvl = LEVEL_MID;
    end else if (dot > 0 && crs <= dot && -crs <= dot) begin
      xr  = dot;
      yr  = crs;
      ang = 0;
      while (xr < NORM_LO) begin
        xr = xr * 2;
        yr = yr * 2;
      end
      while (xr >= NORM_HI) begin
        xr = xr >>> 1;
        yr = yr >>> 1;
      end
      // Vectoring rotation: drive yr to zero and sum the angles used.
      for (k = 0; k < 16; k++) begin
        dx = yr >>> k;
        dy = xr >>> k;
        if (yr >= 0) begin
          xr  = xr + dx;
          yr  = yr - dy;
          ang = ang + atan_tab[k];
        end else begin
          xr  = xr - dx;
          yr  = yr + dy;
          ang = ang - atan_tab[k];
        end
      end
      lvl = LEVEL_MID + ((ang + LEVEL_RND) >>> (30 - TB));
      if (lvl < 0) lvl = 0;
      if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
    end else begin
      // Outside +-pi/4, or behind the reference: pinned to one end of the scale.
      res.clamp = 1'b1;
      lvl = (crs >= 0) ? LEVEL_TOP : 0;
    end
    res.level = lvl[TB-1:0];

    sh = int'(shift_shadow);
    if (sh < 1) sh = 1;
    if (sh > 16) sh = 16;
    gravity_ref_y = gravity_ref_y + ((sy * 65536 - gravity_ref_y) >>> sh);
    gravity_ref_z = gravity_ref_z + ((sz * 65536 - gravity_ref_z) >>> sh);
    if (gravity_ref_y > REF_LIM - 1) gravity_ref_y = REF_LIM - 1;
    if (gravity_ref_y < -REF_LIM) gravity_ref_y = -REF_LIM;
    if (gravity_ref_z > REF_LIM - 1) gravity_ref_z = REF_LIM - 1;
    if (gravity_ref_z < -REF_LIM) gravity_ref_z = -REF_LIM;
  endtask

  // Sample driver. A word is predicted at the edge where it is accepted; the
  // next word (or an idle burst) is chosen whenever the channel is free.
  always @(posedge clk) begin
    if (rst) begin
      s_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (s_if.valid && s_if.ready) begin
        track_tilt(s_if.accel_y, s_if.accel_z, want_word);
        tilt_expect_q.push_back(want_word);
      end
      if (!s_if.valid || s_if.ready) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          s_if.valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 10) begin
          // Idle burst, this cycle included; send_gap holds the rest of it.
          send_gap = $urandom_range(0, 13);
          s_if.valid <= 1'b0;
        end else if (accel_pending_q.size() != 0) begin
          next_word = accel_pending_q.pop_front();
          s_if.valid   <= 1'b1;
          s_if.accel_y <= next_word.y;
          s_if.accel_z <= next_word.z;
        end else begin
          s_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted word is compared with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      r_if.ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (r_if.valid && r_if.ready) begin
        got_word.level = r_if.tilt_level;
        got_word.clamp = r_if.angle_clamped;
        levels_seen <= levels_seen + 1;
        if (tilt_expect_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected tilt word: level %0d clamp %0d", got_word.level,
                     got_word.clamp);
          mismatches = mismatches + 1;
        end else begin
          want_word = tilt_expect_q.pop_front();
          if (got_word.level !== want_word.level || got_word.clamp !== want_word.clamp) begin
            if (mismatches < 10)
              $display("tilt word %0d: expected level %0d clamp %0d, got level %0d clamp %0d",
                       levels_seen, want_word.level, want_word.clamp, got_word.level,
                       got_word.clamp);
            mismatches = mismatches + 1;
          end
        end
      end
      if (hold_left > 0) begin
        r_if.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap = take_gap - 1;
        r_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 8) begin
        take_gap = $urandom_range(0, 13);
        r_if.ready <= 1'b0;
      end else begin
        r_if.ready <= 1'b1;
      end
    end
  end

  // One long hold-off on the result side. The sender keeps offering words, so
  // the output register fills and the block has to stall its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && levels_seen >= HOLD_AFTER) begin
      hold_left <= LONG_HOLD;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic queue_sample(input int y, input int z);
    accel_word_t w;
    w.y = y[SB-1:0];
    w.z = z[SB-1:0];
    accel_pending_q.push_back(w);
  endtask

  task automatic wait_drained();
    while (accel_pending_q.size() != 0 || s_if.valid || tilt_expect_q.size() != 0)
      @(negedge clk);
  endtask

  // The shift register is only written once the block has finished every
  // word in flight and has had time to settle.
  task automatic set_shift(input logic [4:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    shift_shadow = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Random samples. Most look like gravity seen by a tilting device, so the
  // reference stays meaningful and the angle sweeps through both ends of the
  // range; the rest are tiny vectors, arbitrary words, flipped devices,
  // full-scale corners and zero vectors.
  task automatic queue_random(input int count);
    int n, pick, y, z;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        y = int'($urandom_range(0, 6000)) - 3000;
        z = int'($urandom_range(1500, 3000));
      end else if (pick < 65) begin
        y = int'($urandom_range(0, 16)) - 8;
        z = int'($urandom_range(0, 16)) - 8;
      end else if (pick < 85) begin
        y = int'($urandom_range(0, 65535)) - 32768;
        z = int'($urandom_range(0, 65535)) - 32768;
      end else if (pick < 93) begin
        y = int'($urandom_range(0, 6000)) - 3000;
        z = -int'($urandom_range(1500, 3000));
      end else if (pick < 97) begin
        y = $urandom_range(0, 1) ? 32767 : -32768;
        z = $urandom_range(0, 1) ? 32767 : -32768;
      end else begin
        y = 0;
        z = 0;
      end
      queue_sample(y, z);
    end
  endtask

  initial begin
    int n;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    s_if.valid   = 1'b0;
    s_if.accel_y = '0;
    s_if.accel_z = '0;
    r_if.ready   = 1'b0;
    mismatches   = 0;
    levels_seen  = 0;
    cycle_count  = 0;
    calm         = 1'b0;
    gravity_ref_y = tat_pkg::REF_RESET_Y;
    gravity_ref_z = tat_pkg::REF_RESET_Z;
    shift_shadow  = tat_pkg::SHIFT_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // With the fastest smoothing, a steady sample below the reset reference
    // pulls the reference exactly onto it: every step halves the distance
    // and the floor rounding carries the last unit.
    set_shift(5'd1);
    for (n = 0; n < 28; n++) queue_sample(1000, 1000);

    // Register value 0 acts as 1, so the halving stays exact. With the
    // reference at (R, R) the first sample lies exactly on +pi/4. The
    // reference then becomes (R, R/2), for which the second sample lies
    // exactly on -pi/4, and then (R, 7R/4), for which the third sample points
    // straight back: zero cross product with a negative dot product.
    set_shift(5'd0);
    queue_sample(1000, 0);
    queue_sample(1000, 3000);
    queue_sample(-4000, -7000);

    // Full-scale corners, axes, a zero vector, two tiny vectors and a moderate sample, with a shift
    // above the top of the range.
    set_shift(5'd31);
    queue_sample(0, 0);
    queue_sample(32767, 32767);
    queue_sample(-32768, -32768);
    queue_sample(32767, -32768);
    queue_sample(-32768, 32767);
    queue_sample(32767, 0);
    queue_sample(-32768, 0);
    queue_sample(0, 32767);
    queue_sample(0, -32768);
    queue_sample(1, -1);
    queue_sample(-1, 1);
    queue_sample(1436, 2059);

    set_shift(5'd16);
    queue_random(110);
    set_shift(5'd3);
    queue_random(108);
    set_shift(5'd17);
    queue_random(108);
    set_shift(5'd8);
    queue_random(108);
    set_shift(5'd2);
    queue_random(108);

    // Last stretch at full rate on both sides.
    set_shift(5'd12);
    calm = 1'b1;
    queue_random(108);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tat_pkg.sv
rtl/tat_sample_if.sv
rtl/tat_result_if.sv
rtl/tilt_angle_tracker.sv
tb/sv/testbench.sv
